/* src/vspm_pkg.sv */
// Shared types, constants and the sample magnitude table of the PWM sample mapper.
package vspm_pkg;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned SAMPLE_W   = 8;
  localparam int unsigned SCALE_W    = 11;
  localparam int unsigned TOL_W      = 10;
  localparam int unsigned PERIOD_W   = 16;
  localparam int unsigned DUTY_W     = 10;
  localparam int unsigned MAG_W      = 8;

  localparam int unsigned AMP_SHIFT  = 10;
  localparam int unsigned DUTY_SHIFT = 9;
  localparam int unsigned STEP_SHIFT = 10;

  localparam logic [DUTY_W-1:0]   DUTY_MAX  = 10'd1023;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX = 16'hFFFF;

  localparam logic [SCALE_W-1:0]  SCALE_RST      = 11'd768;
  localparam logic [TOL_W-1:0]    TOL_RST        = 10'd16;
  localparam logic [PERIOD_W-1:0] PERIOD_MIN_RST = 16'd125;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX_RST = 16'd250;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_SCALE  = 8'd0,
    CFG_TOLERANCE  = 8'd1,
    CFG_PERIOD_MIN = 8'd2,
    CFG_PERIOD_MAX = 8'd3
  } cfg_reg_e;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SUM  = 6'b000010,
    S_MEAN = 6'b000100,
    S_AMP  = 6'b001000,
    S_MUL  = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  // Square-root magnitude around the silence code 128.
  localparam logic [MAG_W-1:0] MAG_TABLE [256] = '{
    8'd255,8'd254,8'd252,8'd251,8'd250,8'd249,8'd248,8'd247,
    8'd246,8'd245,8'd244,8'd243,8'd242,8'd241,8'd240,8'd239,
    8'd238,8'd237,8'd236,8'd235,8'd234,8'd233,8'd232,8'd230,
    8'd229,8'd228,8'd227,8'd226,8'd225,8'd224,8'd223,8'd221,
    8'd220,8'd219,8'd218,8'd217,8'd216,8'd215,8'd213,8'd212,
    8'd211,8'd210,8'd209,8'd207,8'd206,8'd205,8'd204,8'd202,
    8'd201,8'd200,8'd199,8'd197,8'd196,8'd195,8'd193,8'd192,
    8'd191,8'd189,8'd188,8'd187,8'd185,8'd184,8'd183,8'd181,
    8'd180,8'd178,8'd177,8'd176,8'd174,8'd173,8'd171,8'd170,
    8'd168,8'd167,8'd165,8'd164,8'd162,8'd160,8'd159,8'd157,
    8'd156,8'd154,8'd152,8'd151,8'd149,8'd147,8'd146,8'd144,
    8'd142,8'd140,8'd138,8'd137,8'd135,8'd133,8'd131,8'd129,
    8'd127,8'd125,8'd123,8'd121,8'd119,8'd117,8'd114,8'd112,
    8'd110,8'd108,8'd105,8'd103,8'd100,8'd98, 8'd95, 8'd92,
    8'd90, 8'd87, 8'd84, 8'd81, 8'd78, 8'd74, 8'd71, 8'd67,
    8'd63, 8'd59, 8'd55, 8'd50, 8'd45, 8'd39, 8'd31, 8'd22,
    8'd0,  8'd22, 8'd31, 8'd39, 8'd45, 8'd50, 8'd55, 8'd59,
    8'd63, 8'd67, 8'd71, 8'd74, 8'd78, 8'd81, 8'd84, 8'd87,
    8'd90, 8'd92, 8'd95, 8'd98, 8'd100,8'd103,8'd105,8'd108,
    8'd110,8'd112,8'd114,8'd117,8'd119,8'd121,8'd123,8'd125,
    8'd127,8'd129,8'd131,8'd133,8'd135,8'd137,8'd138,8'd140,
    8'd142,8'd144,8'd146,8'd147,8'd149,8'd151,8'd152,8'd154,
    8'd156,8'd157,8'd159,8'd160,8'd162,8'd164,8'd165,8'd167,
    8'd168,8'd170,8'd171,8'd173,8'd174,8'd176,8'd177,8'd178,
    8'd180,8'd181,8'd183,8'd184,8'd185,8'd187,8'd188,8'd189,
    8'd191,8'd192,8'd193,8'd195,8'd196,8'd197,8'd199,8'd200,
    8'd201,8'd202,8'd204,8'd205,8'd206,8'd207,8'd209,8'd210,
    8'd211,8'd212,8'd213,8'd215,8'd216,8'd217,8'd218,8'd219,
    8'd220,8'd221,8'd223,8'd224,8'd225,8'd226,8'd227,8'd228,
    8'd229,8'd230,8'd232,8'd233,8'd234,8'd235,8'd236,8'd237,
    8'd238,8'd239,8'd240,8'd241,8'd242,8'd243,8'd244,8'd245,
    8'd246,8'd247,8'd248,8'd249,8'd250,8'd251,8'd252,8'd254
  };

endpackage

/* src/vspm_if.sv */
// Channel interfaces of the PWM sample mapper: sample input, result output, register writes.
interface vspm_in_if
  import vspm_pkg::*;
#(
  parameter int unsigned ADC_BITS = 10
);
  logic                 valid;
  logic                 ready;
  logic [SAMPLE_W-1:0]  audio_sample;
  logic [ADC_BITS-1:0]  volume_reading;

  modport source (output valid, audio_sample, volume_reading, input ready);
  modport sink   (input valid, audio_sample, volume_reading, output ready);
endinterface

interface vspm_out_if
  import vspm_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [DUTY_W-1:0]    pwm_duty;
  logic [PERIOD_W-1:0]  pwm_period_us;
  logic                 period_updated;

  modport source (output valid, pwm_duty, pwm_period_us, period_updated, input ready);
  modport sink   (input valid, pwm_duty, pwm_period_us, period_updated, output ready);
endinterface

interface vspm_cfg_if
  import vspm_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [CFG_IDX_W-1:0]   reg_index;
  logic [CFG_DATA_W-1:0]  wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

/* src/volume_scaled_pwm_sample_mapper_core.sv */
// Top level of the PWM sample mapper: volume window memory, sequencer and output register.
//
// Usage: in_i takes one word per audio sample (8-bit sample, ADC_BITS volume reading).
// out_o returns one word per input word: PWM duty, current PWM period in microseconds
// and a flag that marks a recomputed period. cfg_i writes the four control registers
// (scale, tolerance, period at zero and at full volume); it is always ready. cfg_i must
// be written by the user only while the block is idle; the block does not enforce this.
// Sequencing: an accepted word passes through the states S_SUM, S_MEAN, S_AMP, S_MUL
// and S_OUT to the output register, and in_i is ready again right after the result is
// loaded, so no new word is taken before the last one is through. The steps are:
// window memory read, sum update with write-back, reciprocal multiply for the mean,
// scale multiply, duty and period multiplies, then output.
// Reset: registers return to their defaults, the period reads 0 until the first
// recompute, and window entries not yet written read as zero through a fill flag that
// is set when the write pointer first wraps; there is no clearing pass.
// Stall: a finished result waits in the output register while a new word is accepted
// and processed; the sequencer holds in its last step until the output register frees.
module volume_scaled_pwm_sample_mapper_core
  import vspm_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 128,
  parameter int unsigned ADC_BITS     = 10
) (
  input  logic clk_i,
  input  logic rst_ni,
  vspm_in_if.sink    in_i,
  vspm_out_if.source out_o,
  vspm_cfg_if.sink   cfg_i
);

  localparam int unsigned PTR_W   = $clog2(WINDOW_DEPTH);
  localparam int unsigned SUM_W   = ADC_BITS + PTR_W;
  localparam int unsigned MEAN_SH = SUM_W + PTR_W;
  localparam int unsigned RECIP_W = SUM_W + 1;
  localparam int unsigned MP_W    = SUM_W + RECIP_W;
  localparam longint unsigned RECIP =
      ((64'd1 << MEAN_SH) + WINDOW_DEPTH - 1) / WINDOW_DEPTH;
  localparam int unsigned AP_W    = ADC_BITS + SCALE_W;
  localparam int unsigned AMP_W   = AP_W - AMP_SHIFT;
  localparam int unsigned DP_W    = AMP_W + MAG_W;
  localparam int unsigned DLT_W   = PERIOD_W + 1;
  localparam int unsigned PP_W    = AMP_W + 1 + DLT_W;
  localparam int unsigned ST_W    = PP_W - STEP_SHIFT;
  localparam int unsigned PS_W    = ST_W + 1;
  localparam logic [PTR_W-1:0]   PTR_LAST  = PTR_W'(WINDOW_DEPTH - 1);
  localparam logic [RECIP_W-1:0] RECIP_VAL = RECIP_W'(RECIP);
  localparam logic signed [PS_W-1:0] PER_CLAMP = PS_W'(PERIOD_MAX);

  // Control registers.
  logic [SCALE_W-1:0]  scale_q;
  logic [TOL_W-1:0]    tol_q;
  logic [PERIOD_W-1:0] per_min_q, per_max_q;

  // Block state.
  state_e              state_q, state_d;
  logic [PTR_W-1:0]    ptr_q;
  logic                filled_q;
  logic [SUM_W-1:0]    sum_q;
  logic [ADC_BITS-1:0] accepted_q;
  logic [PERIOD_W-1:0] period_q;

  // Per-word working registers.
  logic [SAMPLE_W-1:0] sample_q;
  logic [ADC_BITS-1:0] reading_q;
  logic [ADC_BITS-1:0] mean_q;
  logic [AMP_W-1:0]    amp_q;
  logic                upd_q;
  logic [DUTY_W-1:0]   duty_q;
  logic signed [ST_W-1:0] step_q;

  // Output register.
  logic                out_valid_q;
  logic [DUTY_W-1:0]   out_duty_q;
  logic [PERIOD_W-1:0] out_period_q;
  logic                out_upd_q;

  // Window memory.
  logic [ADC_BITS-1:0] window_mem [WINDOW_DEPTH];
  logic [ADC_BITS-1:0] rdata_q;

  logic in_acc, out_load, mem_we;
  logic [ADC_BITS-1:0]  old_val;
  logic [SUM_W-1:0]     sum_d;
  logic [MP_W-1:0]      mean_prod;
  logic [AP_W-1:0]      amp_prod;
  logic [ADC_BITS-1:0]  diff;
  logic [DP_W-1:0]      duty_prod;
  logic [DP_W-1:0]      duty_shr;
  logic [DUTY_W-1:0]    duty_d;
  logic signed [DLT_W-1:0] delta;
  logic signed [PP_W-1:0]  per_prod;
  logic signed [PS_W-1:0]  per_sum;
  logic [PERIOD_W-1:0]     per_clamped;

  assign in_i.ready  = (state_q == S_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign out_load    = (state_q == S_OUT) && (!out_valid_q || out_o.ready);
  assign mem_we      = (state_q == S_SUM);

  assign out_o.valid          = out_valid_q;
  assign out_o.pwm_duty       = out_duty_q;
  assign out_o.pwm_period_us  = out_period_q;
  assign out_o.period_updated = out_upd_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      window_mem[ptr_q] <= reading_q;
    end
    if (in_acc) begin
      rdata_q <= window_mem[ptr_q];
    end
  end

  always_comb begin
    // Entries ahead of the pointer read as zero until the first wrap.
    old_val   = filled_q ? rdata_q : '0;
    sum_d     = sum_q - SUM_W'(old_val) + SUM_W'(reading_q);
    mean_prod = MP_W'(sum_q) * MP_W'(RECIP_VAL);
    amp_prod  = AP_W'(mean_q) * AP_W'(scale_q);
    diff      = (mean_q > accepted_q) ? (mean_q - accepted_q) : (accepted_q - mean_q);
    duty_prod = DP_W'(amp_q) * DP_W'(MAG_TABLE[sample_q]);
    duty_shr  = duty_prod >> DUTY_SHIFT;
    duty_d    = (32'(duty_shr) > 32'(DUTY_MAX)) ? DUTY_MAX : DUTY_W'(duty_shr);
    delta     = $signed({1'b0, per_max_q}) - $signed({1'b0, per_min_q});
    per_prod  = PP_W'($signed({1'b0, amp_q})) * PP_W'(delta);
    per_sum   = PS_W'(step_q) + $signed(PS_W'({1'b0, per_min_q}));
    priority if (per_sum < 0) begin
      per_clamped = '0;
    end else if (per_sum > PER_CLAMP) begin
      per_clamped = PERIOD_MAX;
    end else begin
      per_clamped = PERIOD_W'(per_sum);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_acc) state_d = S_SUM;
      S_SUM:   state_d = S_MEAN;
      S_MEAN:  state_d = S_AMP;
      S_AMP:   state_d = S_MUL;
      S_MUL:   state_d = S_OUT;
      S_OUT:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q   <= SCALE_RST;
      tol_q     <= TOL_RST;
      per_min_q <= PERIOD_MIN_RST;
      per_max_q <= PERIOD_MAX_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.reg_index)
        CFG_MAX_SCALE:  scale_q   <= cfg_i.wdata[SCALE_W-1:0];
        CFG_TOLERANCE:  tol_q     <= cfg_i.wdata[TOL_W-1:0];
        CFG_PERIOD_MIN: per_min_q <= cfg_i.wdata[PERIOD_W-1:0];
        CFG_PERIOD_MAX: per_max_q <= cfg_i.wdata[PERIOD_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ptr_q       <= '0;
      filled_q    <= 1'b0;
      sum_q       <= '0;
      accepted_q  <= '0;
      period_q    <= '0;
      out_valid_q <= 1'b0;
      upd_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_SUM) begin
        sum_q <= sum_d;
        if (ptr_q == PTR_LAST) begin
          ptr_q    <= '0;
          filled_q <= 1'b1;
        end else begin
          ptr_q <= ptr_q + 1'b1;
        end
      end
      if (state_q == S_AMP) begin
        upd_q <= (32'(diff) > 32'(tol_q));
        if (32'(diff) > 32'(tol_q)) begin
          accepted_q <= mean_q;
        end
      end
      if (out_load && upd_q) begin
        period_q <= per_clamped;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q  <= in_i.audio_sample;
      reading_q <= in_i.volume_reading;
    end
    if (state_q == S_MEAN) begin
      mean_q <= mean_prod[MEAN_SH +: ADC_BITS];
    end
    if (state_q == S_AMP) begin
      amp_q <= amp_prod[AMP_SHIFT +: AMP_W];
    end
    if (state_q == S_MUL) begin
      duty_q <= duty_d;
      step_q <= per_prod[PP_W-1:STEP_SHIFT];
    end
    if (out_load) begin
      out_duty_q   <= duty_q;
      out_period_q <= upd_q ? per_clamped : period_q;
      out_upd_q    <= upd_q;
    end
  end

`ifndef SYNTHESIS
  // A waiting result always shows the period the block holds now.
  a_out_period_current: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_period_q == period_q)
    else $error("output period differs from stored period");

  // Before any word has been written the running sum is empty.
  a_sum_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!filled_q && ptr_q == '0) |-> sum_q == '0)
    else $error("window sum nonzero before first write");

  // The fill flag rises only on a pointer wrap.
  a_fill_on_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(filled_q) |-> ptr_q == '0 && $past(ptr_q) == PTR_LAST)
    else $error("fill flag set without pointer wrap");
`endif

endmodule
